FILE: rtl/tsh_pkg.sv
// tsh_pkg: shared widths and the table entry type of the two-sum hash probe block
// depends on nothing; used by the channel interfaces, the hash unit, the table and the top
`default_nettype none

package tsh_pkg;

	// fixed field widths
	localparam int KEY_W     = 32;
	localparam int POS_W     = 16;
	localparam int OUT_POS_W = 17;
	localparam int CNT_W     = 17;
	localparam int EPOCH_W   = 8;

	// one table slot: list epoch tag, stored key, 0-based position
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [KEY_W-1:0]   key;
		logic [POS_W-1:0]   pos;
	} entry_t;

endpackage

`default_nettype wire

FILE: rtl/tsh_chan_if.sv
// tsh_chan_if: valid/ready channel interfaces for items, results and the config write
// depends on tsh_pkg for field widths
`default_nettype none

interface tsh_item_if;
	logic                             valid;
	logic                             ready;
	logic signed [tsh_pkg::KEY_W-1:0] value;
	logic                             restart;

	modport source (output valid, output value, output restart, input ready);
	modport sink   (input valid, input value, input restart, output ready);
endinterface

interface tsh_result_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [tsh_pkg::OUT_POS_W-1:0] first_position;
	logic [tsh_pkg::OUT_POS_W-1:0] second_position;
	logic                           dropped;
	logic                           ignored;

	modport source (output valid, output found, output first_position,
		output second_position, output dropped, output ignored, input ready);
	modport sink   (input valid, input found, input first_position,
		input second_position, input dropped, input ignored, output ready);
endinterface

interface tsh_cfg_if;
	logic                             valid;
	logic                             ready;
	logic signed [tsh_pkg::KEY_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tsh_hash.sv
// tsh_hash: home slot unit, non-negative key modulo the table size
// depends on tsh_pkg; the table size is a power of two, so the remainder is a mask
`default_nettype none

module tsh_hash #(
	parameter int AW = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [tsh_pkg::KEY_W-1:0] key,
	output logic                           done,
	output logic [AW-1:0]                  slot
);

	logic          done_q;
	logic [AW-1:0] slot_q;

	// low bits of the two's complement key are already the non-negative remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			slot_q <= key[AW-1:0];
		end
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

`default_nettype wire

FILE: rtl/tsh_table.sv
// tsh_table: slot memory holding epoch tag, key and position per slot
// depends on tsh_pkg::entry_t; one write port, one registered read port
`default_nettype none

module tsh_table #(
	parameter int TABLE_SIZE = 512,
	parameter int AW         = 9
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire tsh_pkg::entry_t wr_entry,
	input  wire logic [AW-1:0]   rd_addr,
	output tsh_pkg::entry_t      rd_entry
);

	tsh_pkg::entry_t mem [TABLE_SIZE];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_entry <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/two_sum_hash_probe_top.sv
// two_sum_hash_probe_top: streaming two-sum over an open-addressed hash table
// sequence: an ignored item goes straight to emit; others hash and probe for the complement
//   and, on a miss, hash and probe again to insert; TABLE_SIZE must be a power of two
// throughput: one word at a time, set by the probe sequencer and the single table read port
// reset: asynchronous, active low; a clearing pass over every table slot follows reset and
//   every 255th restart, during which no word is taken (config writes are)
`default_nettype none

module two_sum_hash_probe_top #(
	parameter int TABLE_SIZE = 512,
	parameter int MAX_ITEMS  = 65536
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tsh_cfg_if.sink      cfg,
	tsh_item_if.sink     item,
	tsh_result_if.source result
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);

	typedef enum logic [7:0] {
		S_CLEAR     = 8'b0000_0001,
		S_IDLE      = 8'b0000_0010,
		S_START     = 8'b0000_0100,
		S_HASH_LOOK = 8'b0000_1000,
		S_LOOK      = 8'b0001_0000,
		S_HASH_INS  = 8'b0010_0000,
		S_INS       = 8'b0100_0000,
		S_EMIT      = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic                           found;
		logic [tsh_pkg::OUT_POS_W-1:0] first_position;
		logic [tsh_pkg::OUT_POS_W-1:0] second_position;
		logic                           dropped;
		logic                           ignored;
	} result_t;

	state_t                      state_q;
	logic [tsh_pkg::KEY_W-1:0]   target_q;
	logic [tsh_pkg::KEY_W-1:0]   value_q;
	logic [tsh_pkg::KEY_W-1:0]   key_q;
	logic [tsh_pkg::EPOCH_W-1:0] epoch_q;
	logic                        pend_q;
	logic [tsh_pkg::CNT_W-1:0]   counter_q;
	logic                        pair_done_q;
	logic [AW-1:0]               p_q;
	logic [CW-1:0]               c_q;
	logic [AW-1:0]               clr_q;
	result_t                     res_q;
	result_t                     out_q;
	logic                        out_valid_q;

	logic                        hash_start;
	logic [tsh_pkg::KEY_W-1:0]   hash_key;
	logic                        hash_done;
	logic [AW-1:0]               hash_slot;
	logic [AW-1:0]               rd_addr;
	tsh_pkg::entry_t             rd_entry;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	tsh_pkg::entry_t             wr_entry;
	logic                        slot_live;
	logic                        key_match;
	logic [CW-1:0]               c_inc;
	logic                        probe_end;
	logic [AW:0]                 sum;
	logic [AW-1:0]               next_p;
	logic                        skip;
	logic                        look_miss;
	logic                        collide;
	logic                        emit_ok;

	// handshakes
	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == S_IDLE);
	assign emit_ok    = !out_valid_q || result.ready;

	assign result.valid           = out_valid_q;
	assign result.found           = out_q.found;
	assign result.first_position  = out_q.first_position;
	assign result.second_position = out_q.second_position;
	assign result.dropped         = out_q.dropped;
	assign result.ignored         = out_q.ignored;

	// slot compare and next probe slot (step grows by one each collision)
	assign slot_live = (rd_entry.tag == epoch_q);
	assign key_match = (rd_entry.key == key_q);
	assign collide   = slot_live && !key_match;
	assign c_inc     = c_q + CW'(1);
	assign probe_end = (c_inc == CW'(TABLE_SIZE));
	assign sum       = {1'b0, p_q} + (AW+1)'(c_inc);
	assign next_p    = (sum >= (AW+1)'(TABLE_SIZE)) ?
		AW'(sum - (AW+1)'(TABLE_SIZE)) : sum[AW-1:0];
	assign look_miss = !slot_live || (collide && probe_end);
	assign skip      = pair_done_q || (counter_q >= tsh_pkg::CNT_W'(MAX_ITEMS));

	// hash unit is shared by the complement lookup and the insert
	assign hash_start = ((state_q == S_START) && !skip) || ((state_q == S_LOOK) && look_miss);
	assign hash_key   = (state_q == S_START) ? target_q - value_q : value_q;
	assign rd_addr    = hash_done ? hash_slot : next_p;

	// table writes: clearing sweep or insert into an empty slot
	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = p_q;
		wr_entry.tag   = epoch_q;
		wr_entry.key   = key_q;
		wr_entry.pos   = counter_q[tsh_pkg::POS_W-1:0];
		if (state_q == S_CLEAR) begin
			wr_en        = 1'b1;
			wr_addr      = clr_q;
			wr_entry.tag = '0;
		end else if ((state_q == S_INS) && !slot_live && (c_q < CW'(TABLE_SIZE / 2))) begin
			wr_en = 1'b1;
		end
	end

	tsh_hash #(
		.AW (AW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (hash_key),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	tsh_table #(
		.TABLE_SIZE (TABLE_SIZE),
		.AW         (AW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			target_q    <= '0;
			epoch_q     <= tsh_pkg::EPOCH_W'(1);
			pend_q      <= 1'b0;
			counter_q   <= '0;
			pair_done_q <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				target_q <= cfg.data;
			end
			// output word register: load from the sequencer or drain to the sink
			if ((state_q == S_EMIT) && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(TABLE_SIZE - 1)) begin
						clr_q   <= '0;
						epoch_q <= tsh_pkg::EPOCH_W'(1);
						pend_q  <= 1'b0;
						state_q <= pend_q ? S_START : S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						if (item.restart) begin
							counter_q   <= '0;
							pair_done_q <= 1'b0;
							// new epoch hides old slots; sweep when tags run out
							if (&epoch_q) begin
								pend_q  <= 1'b1;
								state_q <= S_CLEAR;
							end else begin
								epoch_q <= epoch_q + tsh_pkg::EPOCH_W'(1);
								state_q <= S_START;
							end
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= skip ? S_EMIT : S_HASH_LOOK;
				end
				S_HASH_LOOK: begin
					if (hash_done) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (slot_live && key_match) begin
						pair_done_q <= 1'b1;
						counter_q   <= counter_q + tsh_pkg::CNT_W'(1);
						state_q     <= S_EMIT;
					end else if (look_miss) begin
						state_q <= S_HASH_INS;
					end
				end
				S_HASH_INS: begin
					if (hash_done) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (!collide || probe_end) begin
						counter_q <= counter_q + tsh_pkg::CNT_W'(1);
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// probe datapath and result assembly
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					value_q <= item.value;
				end
			end
			S_START: begin
				key_q <= target_q - value_q;
				res_q <= {1'b0, {tsh_pkg::OUT_POS_W{1'b0}}, {tsh_pkg::OUT_POS_W{1'b0}},
					1'b0, skip};
			end
			S_HASH_LOOK, S_HASH_INS: begin
				if (hash_done) begin
					p_q <= hash_slot;
					c_q <= '0;
				end
			end
			S_LOOK: begin
				if (slot_live && key_match) begin
					res_q <= {1'b1,
						tsh_pkg::OUT_POS_W'(rd_entry.pos) + tsh_pkg::OUT_POS_W'(1),
						counter_q + tsh_pkg::CNT_W'(1), 1'b0, 1'b0};
				end else if (look_miss) begin
					key_q <= value_q;
				end else begin
					p_q <= next_p;
					c_q <= c_inc;
				end
			end
			S_INS: begin
				if (!slot_live) begin
					res_q.dropped <= (c_q >= CW'(TABLE_SIZE / 2));
				end else if (collide) begin
					if (probe_end) begin
						res_q.dropped <= 1'b1;
					end else begin
						p_q <= next_p;
						c_q <= c_inc;
					end
				end
			end
			S_EMIT: begin
				if (emit_ok) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// a pair names an earlier word, strictly before this one
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.found |->
			(result.first_position != '0) && (result.second_position > result.first_position))
		else $error("pair positions out of order");

	// at most one outcome flag per result word
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> $onehot0({result.found, result.dropped, result.ignored}))
		else $error("conflicting outcome flags");

	// table writes stay inside the table
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr <= AW'(TABLE_SIZE - 1)))
		else $error("table write out of range");

	// hash results only arrive while the sequencer waits for them
	a_hash_wait: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> ((state_q == S_HASH_LOOK) || (state_q == S_HASH_INS)))
		else $error("hash result outside a hash wait");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for two_sum_hash_probe_top, driving item words, writing target_sum
// and checking each result word against an in-bench open-addressing table predictor
// depends on tsh_pkg, the tsh_chan_if interfaces and the rtl top
`timescale 1ns / 100ps

module tb;

	localparam int SLOTS     = 512;
	localparam int LIST_MAX  = 65536;
	localparam int HOLD_AT   = 60;
	localparam int HOLD_LEN  = 300;
	localparam int CALM_LO   = 200;
	localparam int CALM_HI   = 320;
	localparam logic [31:0] KEY_MIN = 32'h8000_0000;
	localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [tsh_pkg::KEY_W-1:0] value;
		logic                      restart;
	} list_word_t;

	typedef struct packed {
		logic                          found;
		logic [tsh_pkg::OUT_POS_W-1:0] first_position;
		logic [tsh_pkg::OUT_POS_W-1:0] second_position;
		logic                          dropped;
		logic                          ignored;
	} pair_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// bench-side copies of everything driven into the block
	logic                      drv_valid = 1'b0;
	logic [tsh_pkg::KEY_W-1:0] drv_value = '0;
	logic                      drv_restart = 1'b0;
	logic                      sink_ready = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic [tsh_pkg::KEY_W-1:0] cfg_data = '0;

	list_word_t   words_to_send[$];
	pair_result_t pairs_due[$];
	bit           word_taken = 1'b0;
	int           taken_count = 0;
	int           errors = 0;
	int           hold_left = 0;
	bit           hold_spent = 1'b0;
	logic         calm;

	// predictor state: stored keys, positions, occupancy, list counter, pair flag
	logic [tsh_pkg::KEY_W-1:0] sum_target = '0;
	logic [tsh_pkg::KEY_W-1:0] tab_key [SLOTS];
	logic [tsh_pkg::POS_W-1:0] tab_pos [SLOTS];
	bit                        tab_used [SLOTS];
	logic [tsh_pkg::CNT_W-1:0] list_count = '0;
	bit                        pair_seen = 1'b0;

	tsh_item_if   item_ch();
	tsh_result_if result_ch();
	tsh_cfg_if    cfg_ch();

	assign item_ch.valid   = drv_valid;
	assign item_ch.value   = drv_value;
	assign item_ch.restart = drv_restart;
	assign result_ch.ready = sink_ready;
	assign cfg_ch.valid    = cfg_valid;
	assign cfg_ch.data     = cfg_data;
	assign calm = taken_count >= CALM_LO && taken_count < CALM_HI;

	two_sum_hash_probe_top #(
		.TABLE_SIZE(SLOTS),
		.MAX_ITEMS (LIST_MAX)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.item  (item_ch),
		.result(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// non-negative remainder of the signed key
	function automatic int home_slot_of(input logic [31:0] key);
		int k;
		int r;
		k = key;
		r = k % SLOTS;
		if (r < 0) r += SLOTS;
		return r;
	endfunction

	// walk the triangular probe chain; gives hit flag, last slot and collision count
	function automatic bit find_key(input logic [31:0] key, output int slot, output int coll);
		int p;
		int c;
		p = home_slot_of(key);
		c = 0;
		while (tab_used[p] && tab_key[p] != key) begin
			c++;
			if (c >= SLOTS) begin
				slot = p;
				coll = c;
				return 1'b0;
			end
			p = (p + c) % SLOTS;
		end
		slot = p;
		coll = c;
		return tab_used[p];
	endfunction

	// expected result word for one accepted item word, updating the table copy
	function automatic pair_result_t pair_outcome(input logic [31:0] v, input logic restart);
		pair_result_t r;
		int p;
		int c;
		r = '0;
		if (restart) begin
			foreach (tab_used[i]) tab_used[i] = 1'b0;
			list_count = '0;
			pair_seen = 1'b0;
		end
		if (pair_seen || list_count >= LIST_MAX) begin
			r.ignored = 1'b1;
			return r;
		end
		if (find_key(sum_target - v, p, c)) begin
			r.found = 1'b1;
			r.first_position = tab_pos[p] + 17'd1;
			r.second_position = list_count + 17'd1;
			pair_seen = 1'b1;
		end else if (!find_key(v, p, c)) begin
			if (c < SLOTS / 2 && !tab_used[p]) begin
				tab_key[p] = v;
				tab_pos[p] = list_count[tsh_pkg::POS_W-1:0];
				tab_used[p] = 1'b1;
			end else begin
				r.dropped = 1'b1;
			end
		end
		list_count = list_count + 17'd1;
		return r;
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// item driver: next word at the falling edge once the current one is taken
	always @(negedge clk) begin : feed
		list_word_t w;
		if (!drv_valid || word_taken) begin
			if (arst_n && words_to_send.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
				w = words_to_send.pop_front();
				drv_valid <= 1'b1;
				drv_value <= w.value;
				drv_restart <= w.restart;
			end else begin
				drv_valid <= 1'b0;
				drv_value <= $urandom;
				drv_restart <= 1'($urandom_range(1));
			end
		end
	end

	// result sink: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin : drain_ctrl
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			sink_ready <= 1'b0;
		end else if (!hold_spent && taken_count >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_spent <= 1'b1;
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= calm || $urandom_range(99) >= 17;
		end
	end

	// monitor: check result words, then predict for the item word taken at this edge
	always @(posedge clk) begin : watch
		pair_result_t got;
		pair_result_t want;
		got = {result_ch.found, result_ch.first_position, result_ch.second_position,
			result_ch.dropped, result_ch.ignored};
		if (sink_ready && result_ch.valid === 1'b1) begin
			if (pairs_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, actual %h",
					$time, got);
			end else begin
				want = pairs_due.pop_front();
				if (got.found !== want.found)
					flag("found", want.found, got.found);
				if (got.first_position !== want.first_position)
					flag("first_position", want.first_position, got.first_position);
				if (got.second_position !== want.second_position)
					flag("second_position", want.second_position, got.second_position);
				if (got.dropped !== want.dropped)
					flag("dropped", want.dropped, got.dropped);
				if (got.ignored !== want.ignored)
					flag("ignored", want.ignored, got.ignored);
			end
		end
		word_taken = drv_valid && item_ch.ready === 1'b1;
		if (word_taken) begin
			pairs_due.push_back(pair_outcome(drv_value, drv_restart));
			taken_count++;
		end
	end

	function automatic void push_word(input logic [31:0] v, input bit restart);
		list_word_t w;
		w.value = v;
		w.restart = restart;
		words_to_send.push_back(w);
	endfunction

	function automatic logic [31:0] corner_value();
		case ($urandom_range(6))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			4: return 32'h1;
			5: return 32'h5555_5555;
			default: return 32'hAAAA_AAAA;
		endcase
	endfunction

	// one list with random content: pairs, repeats, wide values and clustered home slots
	function automatic void queue_random_list(inout int counted);
		logic [31:0] seen[$];
		logic [31:0] v;
		int len;
		int pick;
		bit restart;
		bit paired;
		len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
		paired = 1'b0;
		for (int i = 0; i < len && !paired; i++) begin
			pick = $urandom_range(99);
			if (pick < 12 && seen.size() != 0) begin
				v = sum_target - seen[$urandom_range(seen.size() - 1)];
				paired = 1'b1;
			end else if (pick < 25 && seen.size() != 0) begin
				v = seen[$urandom_range(seen.size() - 1)];
			end else if (pick < 45) begin
				v = $urandom;
			end else if (pick < 52) begin
				v = corner_value();
			end else begin
				v = $urandom_range(15) + SLOTS * $urandom_range(8000) - SLOTS * 4000;
			end
			// mostly a clean list start, sometimes a stray restart or a missing one
			restart = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
			push_word(v, restart);
			seen.push_back(v);
			counted++;
		end
		// words after a pair only get ignored
		if (paired)
			repeat ($urandom_range(3)) push_word($urandom, 1'b0);
	endfunction

	// target 0: one home slot chain up to the collision limit, then a repeat,
	// a fresh key, a pair and ignored words
	function automatic void queue_crowded_list();
		int h;
		int base;
		h = $urandom_range(1, 200);
		base = $urandom_range(1, 1000);
		for (int k = 0; k <= SLOTS / 2; k++)
			push_word(h + SLOTS * (base + k), k == 0);
		push_word(h + SLOTS * (base + 5), 1'b0);
		push_word(7 + SLOTS * 5000, 1'b0);
		push_word(-(h + SLOTS * base), 1'b0);
		push_word($urandom, 1'b0);
		push_word($urandom, 1'b0);
	endfunction

	task automatic set_target(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		sum_target = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every word is sent and answered, then let the block go quiet
	task automatic settle(input int cycles);
		@(posedge clk);
		while (words_to_send.size() != 0 || drv_valid || pairs_due.size() != 0)
			@(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] phase_targets [5];
		int made;
		phase_targets = '{-32'sd300090, 32'd503, 32'd2, 32'd0, 32'd0};
		phase_targets[3] = $urandom;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset target 0: zero pairs with itself, wrapped complement, repeat, ignore
		push_word(32'h0, 1'b1);
		push_word(KEY_MIN, 1'b0);
		push_word(32'h0, 1'b0);
		push_word(32'd5, 1'b0);
		push_word(KEY_MAX, 1'b1);
		push_word(KEY_MAX, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h8000_0001, 1'b0);
		settle(16);

		// largest target: complement wraps past the top
		set_target(KEY_MAX);
		push_word(32'hFFFF_FFFF, 1'b1);
		push_word(KEY_MIN, 1'b0);
		settle(16);

		// smallest target: complement wraps past the bottom
		set_target(KEY_MIN);
		push_word(32'h1, 1'b1);
		push_word(KEY_MAX, 1'b0);
		push_word(32'h0, 1'b0);
		push_word(KEY_MIN, 1'b1);
		push_word(KEY_MIN, 1'b0);
		push_word(32'h0, 1'b0);
		settle(16);

		// random lists under several targets
		foreach (phase_targets[i]) begin
			set_target(phase_targets[i]);
			made = 0;
			while (made < 16) queue_random_list(made);
			settle(16);
		end

		set_target(32'h0);
		queue_crowded_list();
		settle(16);

		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// watchdog
	initial begin
		#200_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

FILE: two_sum_hash_probe_top.f
rtl/tsh_pkg.sv
rtl/tsh_chan_if.sv
rtl/tsh_hash.sv
rtl/tsh_table.sv
rtl/two_sum_hash_probe_top.sv
tb/tb.sv
